>>> hw/rtl/ypd_pkg.sv
// ----------------------------------------------------------------------------
// ypd_pkg
// Shared types and constants of the yaw PID differential drive controller.
// ----------------------------------------------------------------------------
package ypd_pkg;

  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_READ = 2'd1,
    MODE_HOLD = 2'd2
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OPERATING_MODE = 3'd0,
    REG_YAW_TARGET     = 3'd1,
    REG_GAIN_P         = 3'd2,
    REG_GAIN_I         = 3'd3,
    REG_GAIN_D         = 3'd4,
    REG_DEADBAND       = 3'd5,
    REG_INTEGRAL_CAP   = 3'd6,
    REG_SPEED_LIMIT    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  operating_mode;
    logic [8:0]  yaw_target;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [7:0]  deadband;
    logic [30:0] integral_cap;
    logic [7:0]  speed_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] error_integral;
    logic [8:0]  previous_error;
    logic [7:0]  speed_a;
    logic [7:0]  speed_b;
  } ctl_state_t;

  typedef struct packed {
    logic [8:0] yaw_now;
    logic [8:0] heading_error;
    logic [7:0] speed_a;
    logic [7:0] speed_b;
    logic       drive_updated;
    logic       retracted;
  } result_t;

  localparam logic signed [10:0] YAW_LOW   = -11'sd360;
  localparam logic signed [10:0] YAW_HIGH  = 11'sd720;
  localparam logic signed [10:0] FULL_TURN = 11'sd360;
  localparam logic signed [10:0] HALF_TURN = 11'sd180;
  localparam logic [8:0]         TARGET_MAX = 9'd360;

endpackage

>>> hw/rtl/yaw_pid_differential_drive_core.sv
// ----------------------------------------------------------------------------
// yaw_pid_differential_drive_core
// Heading hold controller for a two-motor differential drive.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     yaw_raw
//   out      output     out_valid / out_ready   yaw_now, heading_error,
//                                               speed_motor_a, speed_motor_b,
//                                               drive_updated, retracted
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A beat is taken into an input register; when the result register is empty
// or being taken, the whole control step lands in the result register and
// is offered on the out channel. One beat per cycle is sustained while
// out_ready stays high; the combinational step closes the loop
// through the integral and the motor speeds. When the result register is
// full and not taken, the input register holds and in_ready drops.
// Reset clears the controller state and loads the register defaults.
// ----------------------------------------------------------------------------
module yaw_pid_differential_drive_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [10:0]                       yaw_raw,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [8:0]                        yaw_now,
  output logic [8:0]                        heading_error,
  output logic [7:0]                        speed_motor_a,
  output logic [7:0]                        speed_motor_b,
  output logic                              drive_updated,
  output logic                              retracted,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ypd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data
);
  import ypd_pkg::*;

  cfg_t       cfg;
  ctl_state_t ctl_state;
  ctl_state_t ctl_state_next;
  result_t    res_next;
  logic       s1_valid;
  logic [10:0] s1_yaw;
  logic       advance;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  ypd_step u_step (
    .cfg     (cfg),
    .cur     (ctl_state),
    .yaw_raw (s1_yaw),
    .nxt     (ctl_state_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.operating_mode <= MODE_IDLE;
      cfg.yaw_target     <= 9'd0;
      cfg.gain_p         <= 16'd256;
      cfg.gain_i         <= 16'd0;
      cfg.gain_d         <= 16'd0;
      cfg.deadband       <= 8'd2;
      cfg.integral_cap   <= 31'd1000;
      cfg.speed_limit    <= 8'd180;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OPERATING_MODE: cfg.operating_mode <= cfg_data[1:0];
        REG_YAW_TARGET:     cfg.yaw_target     <= cfg_data[8:0];
        REG_GAIN_P:         cfg.gain_p         <= cfg_data[15:0];
        REG_GAIN_I:         cfg.gain_i         <= cfg_data[15:0];
        REG_GAIN_D:         cfg.gain_d         <= cfg_data[15:0];
        REG_DEADBAND:       cfg.deadband       <= cfg_data[7:0];
        REG_INTEGRAL_CAP:   cfg.integral_cap   <= cfg_data[30:0];
        REG_SPEED_LIMIT:    cfg.speed_limit    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      ctl_state <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        ctl_state <= ctl_state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_yaw <= yaw_raw;
    end
    if (advance) begin
      yaw_now       <= res_next.yaw_now;
      heading_error <= res_next.heading_error;
      speed_motor_a <= res_next.speed_a;
      speed_motor_b <= res_next.speed_b;
      drive_updated <= res_next.drive_updated;
      retracted     <= res_next.retracted;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_updated && retracted))
    else $error("drive update and retraction reported in one beat");

  a_retract_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && retracted |-> speed_motor_a == speed_motor_b)
    else $error("retraction left unequal motor speeds");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> yaw_now <= 9'd360)
    else $error("wrapped heading out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_yaw))
    else $error("stalled input beat lost");

endmodule

>>> hw/rtl/ypd_step.sv
// ----------------------------------------------------------------------------
// ypd_step
// One control step: heading wrap, error, saturating integral, anti-windup
// retraction and Q8.8 PID drive with clamping of both motor speeds.
// ----------------------------------------------------------------------------
module ypd_step (
  input  ypd_pkg::cfg_t       cfg,
  input  ypd_pkg::ctl_state_t cur,
  input  logic [10:0]         yaw_raw,
  output ypd_pkg::ctl_state_t nxt,
  output ypd_pkg::result_t    res
);
  import ypd_pkg::*;

  function automatic logic [7:0] drive_speed(input logic signed [51:0] v,
                                             input logic [7:0] max_spd);
    logic [43:0] q;
    q = v[51:8];
    if (v[51]) begin
      drive_speed = 8'd0;
    end else if (q > {36'd0, max_spd}) begin
      drive_speed = max_spd;
    end else begin
      drive_speed = q[7:0];
    end
  endfunction

  logic signed [10:0] x;
  logic signed [10:0] xs;
  logic signed [10:0] yw;
  logic [8:0]         yaw;
  logic [8:0]         tgt;
  logic signed [10:0] e_raw;
  logic signed [10:0] e_wrap;
  logic signed [8:0]  err;
  logic signed [32:0] isum;
  logic [31:0]        integ;
  logic [32:0]        mag;
  logic signed [8:0]  sdiff;
  logic [8:0]         sdiff_abs;
  logic [8:0]         err_abs;
  logic signed [10:0] derr;
  logic signed [24:0] prod_p;
  logic signed [47:0] prod_i;
  logic signed [26:0] prod_d;
  logic signed [49:0] pid_sum;
  logic signed [51:0] scaled_a;
  logic signed [51:0] scaled_b;
  logic               hold;
  logic               retract;
  logic               drive;

  always_comb begin
    x = $signed(yaw_raw);
    if (x < YAW_LOW) begin
      xs = YAW_LOW;
    end else if (x > YAW_HIGH) begin
      xs = YAW_HIGH;
    end else begin
      xs = x;
    end
    if (xs < 11'sd0) begin
      yw = xs + FULL_TURN;
    end else if (xs > FULL_TURN) begin
      yw = xs - FULL_TURN;
    end else begin
      yw = xs;
    end
    yaw = yw[8:0];

    tgt = (cfg.yaw_target > TARGET_MAX) ? TARGET_MAX : cfg.yaw_target;
    e_raw = $signed({2'b00, tgt}) - $signed({2'b00, yaw});
    if (e_raw > HALF_TURN) begin
      e_wrap = e_raw - FULL_TURN;
    end else if (e_raw < -HALF_TURN) begin
      e_wrap = e_raw + FULL_TURN;
    end else begin
      e_wrap = e_raw;
    end
    err = e_wrap[8:0];

    isum = 33'($signed(cur.error_integral)) + 33'(err);
    if (isum[32] != isum[31]) begin
      integ = isum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      integ = isum[31:0];
    end
    mag = integ[31] ? (33'd0 - {1'b1, integ}) : {1'b0, integ};

    sdiff = $signed({1'b0, cur.speed_a}) - $signed({1'b0, cur.speed_b});
    sdiff_abs = sdiff[8] ? 9'(-sdiff) : 9'(sdiff);
    err_abs = err[8] ? 9'(-err) : 9'(err);

    derr = 11'(err) - 11'($signed(cur.previous_error));
    prod_p = $signed(cfg.gain_p) * err;
    prod_i = $signed(cfg.gain_i) * $signed(integ);
    prod_d = $signed(cfg.gain_d) * derr;
    pid_sum = 50'(prod_p) + 50'(prod_i) + 50'(prod_d);
    scaled_a = 52'($signed({1'b0, cur.speed_a, 8'd0})) - 52'(pid_sum);
    scaled_b = 52'($signed({1'b0, cur.speed_b, 8'd0})) + 52'(pid_sum);

    hold = (cfg.operating_mode == MODE_HOLD);
    retract = hold && (mag > {2'b00, cfg.integral_cap})
              && (sdiff_abs == {1'b0, cfg.speed_limit});
    drive = hold && !retract && (err_abs > {1'b0, cfg.deadband});

    nxt = cur;
    if (hold) begin
      nxt.previous_error = err;
      nxt.error_integral = integ;
    end
    if (retract) begin
      nxt.error_integral = 32'd0;
      nxt.speed_a = cfg.speed_limit >> 1;
      nxt.speed_b = cfg.speed_limit >> 1;
    end else if (drive) begin
      nxt.speed_a = drive_speed(scaled_a, cfg.speed_limit);
      nxt.speed_b = drive_speed(scaled_b, cfg.speed_limit);
    end

    res.yaw_now       = yaw;
    res.heading_error = hold ? err : 9'd0;
    res.speed_a       = nxt.speed_a;
    res.speed_b       = nxt.speed_b;
    res.drive_updated = drive;
    res.retracted     = retract;
  end

endmodule
